[hdl/rau_pkg.sv]
package rau_pkg;

  localparam int WIDTH = 32;

  localparam logic [3:0] FN_ADD = 4'd0;
  localparam logic [3:0] FN_SUB = 4'd1;
  localparam logic [3:0] FN_MUL = 4'd2;
  localparam logic [3:0] FN_DIV = 4'd3;
  localparam logic [3:0] FN_EQ  = 4'd4;
  localparam logic [3:0] FN_NE  = 4'd5;
  localparam logic [3:0] FN_LT  = 4'd6;
  localparam logic [3:0] FN_GT  = 4'd7;
  localparam logic [3:0] FN_LE  = 4'd8;
  localparam logic [3:0] FN_GE  = 4'd9;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_0   = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // largest magnitude of a negative WIDTH-bit value
  localparam logic [63:0] LIM = 64'd1 << (WIDTH - 1);

  typedef enum logic [1:0] {
    MUL_PA,
    MUL_PB,
    MUL_PD
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     form;
    logic     gcd_init;
    logic     gcd_step;
    logic     div_init;
    logic     div_step;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic arith;
    logic zz;
    logic gcd_done;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

[hdl/rational_arithmetic_unit.sv]
// Comparisons, unused codes and zero over zero go from the request through the
// multiply, form and check states straight to the result; arithmetic also runs
// GCD steps (one compare-subtract or shift per cycle) and shared-divisor restoring division.
// Throughput: one request at a time; the next is taken once the current
// result sits in the output register. Synchronous active-high reset
// returns the controller to idle and empties the output register.
module rational_arithmetic_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // func[3:0], a_num[35:4], a_den[67:36], b_num[99:68], b_den[131:100], zero pad
  input  logic [135:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // res_num[31:0], res_den[63:32], truth[64], status[66:65], zero pad
  output logic [71:0]  m_tdata
);

  rau_pkg::cmd_t cmd;
  rau_pkg::sts_t sts;

  rau_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rau_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .in_data  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

[hdl/rau_datapath.sv]
module rau_datapath (
  input  logic            clk,
  input  logic            rst,
  input  rau_pkg::cmd_t   cmd,
  output rau_pkg::sts_t   sts,
  input  logic [135:0]    in_data,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [71:0]     m_tdata
);

  logic        [3:0]  func;
  logic signed [31:0] an, ad, bn, bd;
  logic signed [31:0] mx, my;
  logic signed [63:0] prod;
  logic signed [63:0] pa, pb, pd;
  logic signed [64:0] nsum;
  logic signed [63:0] dsrc;
  logic               n_neg, d_neg;
  logic        [63:0] n_mag, d_mag;
  logic        [63:0] u, v, g;
  logic        [6:0]  k;
  logic        [63:0] qn, qd, rn, rd;
  logic        [5:0]  cnt;
  logic        [64:0] tn, td;
  logic               ge_n, ge_d;
  logic        [63:0] neg_qn, neg_qd;
  logic        [31:0] r_num, r_den;
  logic               r_truth;
  logic        [1:0]  r_status;
  logic               eq, lt, gt, pd_zero;

  always_comb begin
    case (cmd.mul_sel)
      rau_pkg::MUL_PA: begin
        mx = an;
        my = (func == rau_pkg::FN_MUL) ? bn : bd;
      end
      rau_pkg::MUL_PB: begin
        mx = ad;
        my = bn;
      end
      default: begin
        mx = ad;
        my = bd;
      end
    endcase
  end

  assign prod = mx * my;

  always_comb begin
    case (func)
      rau_pkg::FN_ADD: nsum = {pa[63], pa} + {pb[63], pb};
      rau_pkg::FN_MUL, rau_pkg::FN_DIV: nsum = {pa[63], pa};
      default: nsum = {pa[63], pa} - {pb[63], pb};
    endcase
    dsrc = (func == rau_pkg::FN_DIV) ? pb : pd;
  end

  assign tn   = {rn, qn[63]};
  assign td   = {rd, qd[63]};
  assign ge_n = tn >= {1'b0, g};
  assign ge_d = td >= {1'b0, g};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func <= in_data[3:0];
      an   <= in_data[35:4];
      ad   <= in_data[67:36];
      bn   <= in_data[99:68];
      bd   <= in_data[131:100];
    end
    if (cmd.mul_en) begin
      case (cmd.mul_sel)
        rau_pkg::MUL_PA: pa <= prod;
        rau_pkg::MUL_PB: pb <= prod;
        default:         pd <= prod;
      endcase
    end
    if (cmd.form) begin
      n_neg <= nsum[64];
      n_mag <= nsum[64] ? 64'(-nsum) : nsum[63:0];
      d_neg <= dsrc[63];
      d_mag <= dsrc[63] ? 64'(-dsrc) : 64'(dsrc);
    end
    if (cmd.gcd_init) begin
      u <= n_mag;
      v <= d_mag;
      k <= '0;
    end else if (cmd.gcd_step) begin
      if (!u[0] && !v[0]) begin
        u <= u >> 1;
        v <= v >> 1;
        k <= k + 7'd1;
      end else if (!u[0]) begin
        u <= u >> 1;
      end else if (!v[0]) begin
        v <= v >> 1;
      end else if (u >= v) begin
        u <= u - v;
      end else begin
        v <= v - u;
      end
    end
    if (cmd.div_init) begin
      g   <= (u | v) << k;
      qn  <= n_mag;
      qd  <= d_mag;
      rn  <= '0;
      rd  <= '0;
      cnt <= '0;
    end else if (cmd.div_step) begin
      rn  <= ge_n ? 64'(tn - {1'b0, g}) : tn[63:0];
      rd  <= ge_d ? 64'(td - {1'b0, g}) : td[63:0];
      qn  <= {qn[62:0], ge_n};
      qd  <= {qd[62:0], ge_d};
      cnt <= cnt + 6'd1;
    end
  end

  // result selection
  assign neg_qn  = 64'(-qn);
  assign neg_qd  = 64'(-qd);
  assign pd_zero = (pd == '0);
  assign eq      = (n_mag == '0);
  assign lt      = !pd_zero && !eq && (n_neg != pd[63]);
  assign gt      = !pd_zero && !eq && (n_neg == pd[63]);

  always_comb begin
    r_num    = '0;
    r_den    = '0;
    r_truth  = 1'b0;
    r_status = rau_pkg::ST_OK;
    case (func)
      rau_pkg::FN_ADD, rau_pkg::FN_SUB, rau_pkg::FN_MUL, rau_pkg::FN_DIV: begin
        if (sts.zz) begin
          r_status = rau_pkg::ST_ZERO_0;
        end else if ((n_neg ? (qn > rau_pkg::LIM) : (qn >= rau_pkg::LIM)) ||
                     (d_neg ? (qd > rau_pkg::LIM) : (qd >= rau_pkg::LIM))) begin
          r_status = rau_pkg::ST_OVERFLOW;
        end else begin
          r_num = n_neg ? neg_qn[31:0] : qn[31:0];
          r_den = d_neg ? neg_qd[31:0] : qd[31:0];
        end
      end
      rau_pkg::FN_EQ: r_truth = eq;
      rau_pkg::FN_NE: r_truth = !eq;
      rau_pkg::FN_LT: r_truth = lt;
      rau_pkg::FN_GT: r_truth = gt;
      rau_pkg::FN_LE: r_truth = pd_zero ? eq : !gt;
      rau_pkg::FN_GE: r_truth = pd_zero ? eq : !lt;
      default: r_truth = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {5'd0, r_status, r_truth, r_den, r_num};
    end
  end

  assign sts.arith    = (func <= rau_pkg::FN_DIV);
  assign sts.zz       = (n_mag == '0) && (d_mag == '0);
  assign sts.gcd_done = (u == '0) || (v == '0);
  assign sts.div_last = (cnt == 6'd63);
  assign sts.out_free = !m_tvalid || m_tready;

endmodule

[hdl/rau_controller.sv]
module rau_controller (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  rau_pkg::sts_t sts,
  output rau_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    IDLE, MUL0, MUL1, MUL2, FORM, CHECK, GCD, DIVIDE, FINISH
  } state_t;

  state_t state;

  assign s_tready = (state == IDLE);

  always_comb begin
    cmd = '0;
    cmd.mul_sel = rau_pkg::MUL_PA;
    case (state)
      IDLE:   cmd.load = s_tvalid;
      MUL0:   cmd.mul_en = 1'b1;
      MUL1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = rau_pkg::MUL_PB;
      end
      MUL2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = rau_pkg::MUL_PD;
      end
      FORM:   cmd.form = 1'b1;
      CHECK:  cmd.gcd_init = 1'b1;
      GCD: begin
        cmd.gcd_step = !sts.gcd_done;
        cmd.div_init = sts.gcd_done;
      end
      DIVIDE: cmd.div_step = 1'b1;
      FINISH: cmd.out_load = sts.out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      case (state)
        IDLE:   if (s_tvalid) state <= MUL0;
        MUL0:   state <= MUL1;
        MUL1:   state <= MUL2;
        MUL2:   state <= FORM;
        FORM:   state <= CHECK;
        CHECK:  state <= (sts.arith && !sts.zz) ? GCD : FINISH;
        GCD:    if (sts.gcd_done) state <= DIVIDE;
        DIVIDE: if (sts.div_last) state <= FINISH;
        FINISH: if (sts.out_free) state <= IDLE;
        default: state <= IDLE;
      endcase
    end
  end

endmodule

[hdl/rau_checker.sv]
module rau_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [71:0]  m_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while busy");

  a_status_clear: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[66:65] != 2'd0 |-> m_tdata[64:0] == '0)
    else $error("error status with nonzero result");

  a_truth_only: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[64] |-> m_tdata[63:0] == '0 && m_tdata[66:65] == 2'd0)
    else $error("comparison result carries fraction");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[66:65] != 2'd3 && m_tdata[71:67] == '0)
    else $error("bad status or pad bits");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
